FILE: design/stlp_pkg.sv
// Shared types and constants of the sweep trace line plotter.
package stlp_pkg;

  // Fixed field widths.
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned COLOR_W = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_WINDOW_LEFT      = 3'd0;
  localparam logic [2:0] REG_WINDOW_TOP       = 3'd1;
  localparam logic [2:0] REG_WINDOW_BOTTOM    = 3'd2;
  localparam logic [2:0] REG_TRACE_WIDTH      = 3'd3;
  localparam logic [2:0] REG_MIN_VALUE        = 3'd4;
  localparam logic [2:0] REG_MAX_VALUE        = 3'd5;
  localparam logic [2:0] REG_TRACE_COLOR      = 3'd6;
  localparam logic [2:0] REG_BACKGROUND_COLOR = 3'd7;

  // Line command slots, in the order they are sent.
  localparam logic [1:0] CMD_ERASE   = 2'd0;
  localparam logic [1:0] CMD_SEGMENT = 2'd1;
  localparam logic [1:0] CMD_MARK_BG = 2'd2;
  localparam logic [1:0] CMD_MARK_FG = 2'd3;

  // Input beat.
  typedef struct packed {
    logic signed [VAL_W-1:0] sample;
    logic                    scan_marker;
  } smp_t;

  // Output beat: one draw-line command.
  typedef struct packed {
    logic [COL_W-1:0]   start_x;
    logic [ROW_W-1:0]   start_y;
    logic [COL_W-1:0]   end_x;
    logic [ROW_W-1:0]   end_y;
    logic [COLOR_W-1:0] line_color;
    logic               last_line;
  } cmd_t;

  // Sequencer of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_EMIT
  } top_state_t;

  // Sequencer of the row mapper.
  typedef enum logic [2:0] {
    MAP_IDLE,
    MAP_PREP,
    MAP_MUL,
    MAP_DIV,
    MAP_DONE
  } map_state_t;

endpackage

FILE: design/sweep_trace_line_plotter_top.sv
// Top level of the sweep trace line plotter: registers, point store and command sequencer.
//
// Usage: each beat on the smp channel carries one signed sample and a marker flag
// and plots one column of a sweep-mode trace. The block answers with zero to four
// draw-line beats on the cmd channel: an erase of the old segment (once the sweep
// has wrapped), the new segment from the previous point, and, when the marker flag
// is set, a background and a trace colored vertical marker line. The last command
// of a sample has last_line set; the first sample of each sweep gives none unless
// erasing. Both channels use valid/ready.
// The row is found by a serial divider that retires one quotient bit a cycle (9 steps,
// after the clamping and multiplying steps and before the finishing step); the command
// sequencer then takes one command slot a cycle, skipped or sent, while the receiver
// keeps up. A new sample is taken only after the previous one's last command is loaded.
// A stalled receiver holds the sequencer; the final command of a sample waits in
// the output register while the next sample is already taken.
// Reset clears the column counter and erase mode and loads the register defaults;
// the point store is not cleared and needs no clearing pass.
// Configuration writes take effect at once and must be made while the block is idle.
module sweep_trace_line_plotter_top #(
  parameter int unsigned MAX_COLUMNS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         smp_valid,
  output logic                         smp_ready,
  input  stlp_pkg::smp_t               smp_data,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output stlp_pkg::cmd_t               cmd_data,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [stlp_pkg::VAL_W-1:0]   cfg_wdata
);
  import stlp_pkg::*;

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Configuration registers.
  logic [ROW_W-1:0]        window_left;
  logic [ROW_W-1:0]        window_top;
  logic [ROW_W-1:0]        window_bottom;
  logic [COL_W-1:0]        trace_width;
  logic signed [VAL_W-1:0] min_value;
  logic signed [VAL_W-1:0] max_value;
  logic [COLOR_W-1:0]      trace_color;
  logic [COLOR_W-1:0]      background_color;

  // Sweep state and per-sample registers.
  top_state_t       state, state_next;
  logic [COL_W-1:0] column_index;
  logic             erase_mode;
  logic [COL_W-1:0] cur_col;
  logic             scan_q;
  logic [1:0]       rd_cnt;
  logic [ROW_W-1:0] row_c;
  logic [ROW_W-1:0] row_n;
  logic [ROW_W-1:0] row_p;
  logic [ROW_W-1:0] new_row;
  logic [3:0]       mask;
  logic [1:0]       k;

  // Point store.
  logic [ROW_W-1:0] point_rows [MAX_COLUMNS];
  logic [ROW_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;

  logic             smp_fire;
  logic             map_done;
  logic [ROW_W-1:0] map_row;
  logic [COL_W:0]   w_eff;
  logic [COL_W-1:0] col_inc;
  logic [COL_W-1:0] col_dec;
  logic [3:0]       mask_now;
  logic [2:0]       k_after;
  logic             k_last;
  logic             emit_load;
  logic             k_step;
  logic [COL_W-1:0] x;
  cmd_t             cmd_build;

  assign smp_fire = smp_valid && smp_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_left      <= ROW_W'(0);
      window_top       <= ROW_W'(0);
      window_bottom    <= ROW_W'(239);
      trace_width      <= COL_W'(320);
      min_value        <= -VAL_W'(2048);
      max_value        <= VAL_W'(2047);
      trace_color      <= '1;
      background_color <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW_LEFT:      window_left      <= cfg_wdata[ROW_W-1:0];
        REG_WINDOW_TOP:       window_top       <= cfg_wdata[ROW_W-1:0];
        REG_WINDOW_BOTTOM:    window_bottom    <= cfg_wdata[ROW_W-1:0];
        REG_TRACE_WIDTH:      trace_width      <= cfg_wdata[COL_W-1:0];
        REG_MIN_VALUE:        min_value        <= cfg_wdata;
        REG_MAX_VALUE:        max_value        <= cfg_wdata;
        REG_TRACE_COLOR:      trace_color      <= cfg_wdata;
        REG_BACKGROUND_COLOR: background_color <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Effective sweep width, limited to one column up to the store depth.
  always_comb begin
    if (trace_width == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if ({1'b0, trace_width} > (COL_W+1)'(MAX_COLUMNS)) begin
      w_eff = (COL_W+1)'(MAX_COLUMNS);
    end else begin
      w_eff = {1'b0, trace_width};
    end
  end

  assign col_inc = cur_col + COL_W'(1);
  assign col_dec = cur_col - COL_W'(1);

  // Commands that this sample needs, decided when its row is known.
  always_comb begin
    mask_now = '0;
    mask_now[CMD_ERASE]   = erase_mode && ({1'b0, col_inc} < w_eff);
    mask_now[CMD_SEGMENT] = (cur_col != '0);
    mask_now[CMD_MARK_BG] = (cur_col != '0) && scan_q;
    mask_now[CMD_MARK_FG] = (cur_col != '0) && scan_q;
  end

  // Row mapping unit.
  stlp_row_map u_row_map (
    .clk           (clk),
    .rst           (rst),
    .start         (smp_fire),
    .sample        (smp_data.sample),
    .window_top    (window_top),
    .window_bottom (window_bottom),
    .min_value     (min_value),
    .max_value     (max_value),
    .done          (map_done),
    .row           (map_row)
  );

  // Store reads during mapping: the old row here, then the next and previous columns.
  always_comb begin
    rd_en = (state == ST_MAP) && (rd_cnt != 2'd3);
    case (rd_cnt)
      2'd0:    rd_addr = cur_col[AW-1:0];
      2'd1:    rd_addr = col_inc[AW-1:0];
      default: rd_addr = col_dec[AW-1:0];
    endcase
  end

  // Point store ports: one registered read, one write when the new row is ready.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= point_rows[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_done && (state == ST_MAP)) begin
      point_rows[cur_col[AW-1:0]] <= map_row;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot bookkeeping: a command is last when no later slot is enabled.
  always_comb begin
    k_after = {1'b0, k} + 3'd1;
    k_last  = ((mask >> k_after) == 4'd0);
  end

  // Next state, input handshake and command loading.
  always_comb begin
    state_next = state;
    smp_ready  = 1'b0;
    emit_load  = 1'b0;
    k_step     = 1'b0;
    case (state)
      ST_IDLE: begin
        smp_ready = 1'b1;
        if (smp_valid) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_done) begin
          state_next = (mask_now == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!mask[k]) begin
          if (k == CMD_MARK_FG) begin
            state_next = ST_IDLE;
          end else begin
            k_step = 1'b1;
          end
        end else if (!cmd_valid || cmd_ready) begin
          emit_load = 1'b1;
          if (k_last || (k == CMD_MARK_FG)) begin
            state_next = ST_IDLE;
          end else begin
            k_step = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Column counter, wrap into erase mode, and per-sample captures.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      erase_mode   <= 1'b0;
      rd_cnt       <= '0;
      k            <= CMD_ERASE;
    end else begin
      if (smp_fire) begin
        rd_cnt <= '0;
        if ({1'b0, column_index} >= w_eff) begin
          erase_mode <= 1'b1;
        end
      end else if (state == ST_MAP && rd_cnt != 2'd3) begin
        rd_cnt <= rd_cnt + 2'd1;
      end
      if (state == ST_MAP && map_done) begin
        column_index <= col_inc;
        k            <= CMD_ERASE;
      end else if (k_step) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_fire) begin
      cur_col <= ({1'b0, column_index} >= w_eff) ? '0 : column_index;
      scan_q  <= smp_data.scan_marker;
    end
    if (state == ST_MAP) begin
      case (rd_cnt)
        2'd1:    row_c <= rd_data;
        2'd2:    row_n <= rd_data;
        2'd3:    row_p <= rd_data;
        default: begin
        end
      endcase
      if (map_done) begin
        new_row <= map_row;
        mask    <= mask_now;
      end
    end
  end

  // Command fields for the current slot.
  assign x = COL_W'(window_left) + cur_col;

  always_comb begin
    cmd_build           = '0;
    cmd_build.last_line = k_last;
    case (k)
      CMD_ERASE: begin
        cmd_build.start_x    = x;
        cmd_build.start_y    = row_c;
        cmd_build.end_x      = x + COL_W'(1);
        cmd_build.end_y      = row_n;
        cmd_build.line_color = background_color;
      end
      CMD_SEGMENT: begin
        cmd_build.start_x    = x - COL_W'(1);
        cmd_build.start_y    = row_p;
        cmd_build.end_x      = x;
        cmd_build.end_y      = new_row;
        cmd_build.line_color = trace_color;
      end
      CMD_MARK_BG: begin
        cmd_build.start_x    = x + COL_W'(1);
        cmd_build.start_y    = window_top;
        cmd_build.end_x      = x + COL_W'(1);
        cmd_build.end_y      = window_bottom;
        cmd_build.line_color = background_color;
      end
      default: begin
        cmd_build.start_x    = x + COL_W'(2);
        cmd_build.start_y    = window_top;
        cmd_build.end_x      = x + COL_W'(2);
        cmd_build.end_y      = window_bottom;
        cmd_build.line_color = trace_color;
      end
    endcase
  end

  // Output register: holds a beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (emit_load) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      cmd_data <= cmd_build;
    end
  end

  // The mapper finishes only while the sequencer waits for it.
  a_done_in_map: assert property (@(posedge clk) disable iff (rst)
    map_done |-> (state == ST_MAP))
    else $error("row mapper finished outside the mapping phase");

  // A taken sample moves the sequencer to mapping and closes the input.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    smp_fire |=> (state == ST_MAP) && !smp_ready)
    else $error("sample taken while the previous one is in progress");

  // The column never runs past the store depth.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_index} <= (COL_W+1)'(MAX_COLUMNS))
    else $error("column index beyond the store depth");

  // Erase mode only turns off at reset.
  a_erase_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(erase_mode))
    else $error("erase mode cleared outside reset");

  // A new command is never loaded over one that still waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> (!cmd_valid || cmd_ready))
    else $error("command register overwritten while stalled");

endmodule

FILE: design/stlp_row_map.sv
// Sample to pixel row mapper with a serial restoring divider.
module stlp_row_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [stlp_pkg::VAL_W-1:0] sample,
  input  logic [stlp_pkg::ROW_W-1:0]    window_top,
  input  logic [stlp_pkg::ROW_W-1:0]    window_bottom,
  input  logic signed [stlp_pkg::VAL_W-1:0] min_value,
  input  logic signed [stlp_pkg::VAL_W-1:0] max_value,
  output logic                          done,
  output logic [stlp_pkg::ROW_W-1:0]    row
);
  import stlp_pkg::*;

  // Dividend width: row span times value span magnitude.
  localparam int unsigned NUM_W = ROW_W + VAL_W;

  map_state_t state, state_next;

  logic signed [VAL_W-1:0] s_q;
  logic [VAL_W-1:0]        hs_mag;
  logic [ROW_W-1:0]        dr_mag;
  logic [VAL_W-1:0]        den_mag;
  logic                    neg;
  logic                    den_zero;
  logic [NUM_W-1:0]        work;
  logic [3:0]              step;

  logic signed [VAL_W-1:0] s_clamp;
  logic signed [VAL_W:0]   hs;
  logic signed [VAL_W:0]   den;
  logic signed [ROW_W:0]   dr;
  logic [VAL_W:0]          r2;
  logic [VAL_W:0]          rsub;
  logic                    ge;
  logic [ROW_W-1:0]        q_abs;
  logic [ROW_W-1:0]        q_signed;

  // Clamp the sample and form the signed spans.
  always_comb begin
    if (s_q > max_value) begin
      s_clamp = max_value;
    end else if (s_q < min_value) begin
      s_clamp = min_value;
    end else begin
      s_clamp = s_q;
    end
    hs  = {max_value[VAL_W-1], max_value} - {s_clamp[VAL_W-1], s_clamp};
    den = {max_value[VAL_W-1], max_value} - {min_value[VAL_W-1], min_value};
    dr  = $signed({1'b0, window_bottom}) - $signed({1'b0, window_top});
  end

  // One restoring division step: the partial remainder takes the next dividend bit.
  always_comb begin
    r2   = {work[NUM_W-1:ROW_W], work[ROW_W-1]};
    rsub = r2 - {1'b0, den_mag};
    ge   = (r2 >= {1'b0, den_mag});
  end

  // Apply the quotient sign and offset by the top row.
  always_comb begin
    q_abs    = work[ROW_W-1:0];
    q_signed = neg ? ROW_W'(-q_abs) : q_abs;
    row      = den_zero ? window_top : ROW_W'(window_top + q_signed);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MAP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the done strobe.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      MAP_IDLE: begin
        if (start) begin
          state_next = MAP_PREP;
        end
      end
      MAP_PREP: state_next = MAP_MUL;
      MAP_MUL:  state_next = MAP_DIV;
      MAP_DIV: begin
        if (step == 4'(ROW_W - 1)) begin
          state_next = MAP_DONE;
        end
      end
      MAP_DONE: begin
        done       = 1'b1;
        state_next = MAP_IDLE;
      end
      default: state_next = MAP_IDLE;
    endcase
  end

  // Datapath: capture, magnitudes, product, then one quotient bit a cycle.
  always_ff @(posedge clk) begin
    case (state)
      MAP_IDLE: begin
        if (start) begin
          s_q <= sample;
        end
      end
      MAP_PREP: begin
        hs_mag   <= hs[VAL_W] ? VAL_W'(-hs) : hs[VAL_W-1:0];
        den_mag  <= den[VAL_W] ? VAL_W'(-den) : den[VAL_W-1:0];
        dr_mag   <= dr[ROW_W] ? ROW_W'(-dr) : dr[ROW_W-1:0];
        neg      <= hs[VAL_W] ^ den[VAL_W] ^ dr[ROW_W];
        den_zero <= (den == '0);
      end
      MAP_MUL: begin
        work <= {{VAL_W{1'b0}}, dr_mag} * {{ROW_W{1'b0}}, hs_mag};
        step <= '0;
      end
      MAP_DIV: begin
        work <= {(ge ? rsub[VAL_W-1:0] : r2[VAL_W-1:0]), work[ROW_W-2:0], ge};
        step <= step + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
